/* rtl/core/dtsd_pkg.sv */
// shared types, codes and constant tables of the decimal scaler
package dtsd_pkg;

  localparam int unsigned MaxDecimals = 18;

  localparam logic [0:0] CFG_DECIMALS = 1'b0;
  localparam logic [0:0] CFG_MODE     = 1'b1;

  typedef enum logic [1:0] {
    RM_NEAREST   = 2'd0,
    RM_HALF_EVEN = 2'd1,
    RM_DOWN      = 2'd2,
    RM_EXACT     = 2'd3
  } rnd_mode_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_INPUT = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_PREC  = 2'd3
  } err_e;

  // rounded binary64 product sm * 2^se
  typedef struct packed {
    logic [52:0]        sm;
    logic signed [12:0] se;
    logic [5:0]         bl;  // bit length of sm
    logic [6:0]         k;   // se minus input exponent
  } dbl_t;

  // sideband that travels beside the multiplier stages
  typedef struct packed {
    logic               err_in;
    logic               not_max;
    logic signed [11:0] e;
  } side_t;

  function automatic logic [63:0] pow10(input logic [4:0] d);
    logic [63:0] v;
    case (d)
      5'd0:  v = 64'd1;
      5'd1:  v = 64'd10;
      5'd2:  v = 64'd100;
      5'd3:  v = 64'd1000;
      5'd4:  v = 64'd10000;
      5'd5:  v = 64'd100000;
      5'd6:  v = 64'd1000000;
      5'd7:  v = 64'd10000000;
      5'd8:  v = 64'd100000000;
      5'd9:  v = 64'd1000000000;
      5'd10: v = 64'd10000000000;
      5'd11: v = 64'd100000000000;
      5'd12: v = 64'd1000000000000;
      5'd13: v = 64'd10000000000000;
      5'd14: v = 64'd100000000000000;
      5'd15: v = 64'd1000000000000000;
      5'd16: v = 64'd10000000000000000;
      5'd17: v = 64'd100000000000000000;
      5'd18: v = 64'd1000000000000000000;
      5'd19: v = 64'd10000000000000000000;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  // bit length of pow10
  function automatic logic [6:0] pow10_len(input logic [4:0] d);
    logic [6:0] v;
    case (d)
      5'd0:  v = 7'd1;
      5'd1:  v = 7'd4;
      5'd2:  v = 7'd7;
      5'd3:  v = 7'd10;
      5'd4:  v = 7'd14;
      5'd5:  v = 7'd17;
      5'd6:  v = 7'd20;
      5'd7:  v = 7'd24;
      5'd8:  v = 7'd27;
      5'd9:  v = 7'd30;
      5'd10: v = 7'd34;
      5'd11: v = 7'd37;
      5'd12: v = 7'd40;
      5'd13: v = 7'd44;
      5'd14: v = 7'd47;
      5'd15: v = 7'd50;
      5'd16: v = 7'd54;
      5'd17: v = 7'd57;
      5'd18: v = 7'd60;
      5'd19: v = 7'd64;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/double_to_scaled_decimal_integer.sv */
// binary64 amount to unsigned integer amount * 10^decimals, four rounding modes
// pipeline from input transaction to result valid: decode, 4 multiply/round, 3 finish stages
// throughput: one transaction per cycle; every stage register has its own valid bit
// a stage holds while the stage after it is full and stalled, bubbles close up
// reset: asynchronous active low, clears valid bits, decimals to 0 and mode to nearest
module double_to_scaled_decimal_integer #(
  parameter int unsigned MaxDecimals = dtsd_pkg::MaxDecimals
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] amount_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] scaled_value_o,
  output logic [1:0]  error_code_o
);

  localparam int unsigned NumStages = 8;

  // configuration registers
  logic [4:0]          dec_q;
  dtsd_pkg::rnd_mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q  <= '0;
      mode_q <= dtsd_pkg::RM_NEAREST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtsd_pkg::CFG_DECIMALS: dec_q  <= cfg_wdata_i;
        dtsd_pkg::CFG_MODE:     mode_q <= dtsd_pkg::rnd_mode_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // scale factor; the user must change it only while idle, the block itself does not enforce this
  logic [63:0] x;
  logic [6:0]  xlen;
  assign x    = dtsd_pkg::pow10(dec_q);
  assign xlen = dtsd_pkg::pow10_len(dec_q);

  // pipeline flow: a stage loads when empty or when its content moves on
  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   free;

  always_comb begin
    free[NumStages] = out_ready_i;
    for (int i = NumStages - 1; i >= 0; i--) begin
      free[i] = !vld_q[i] || free[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (free[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < NumStages; i++) begin
        if (free[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign in_ready_o  = free[0];
  assign out_valid_o = vld_q[NumStages-1];

  // decode stage: checks and mantissa/exponent split of the amount and of the next double
  logic [52:0]        m_q, m2_q;
  logic signed [11:0] e_q, e2_q;
  dtsd_pkg::side_t    side_q [0:4];

  always_ff @(posedge clk_i) begin
    logic [62:0] abits, a2;
    logic        nan_inf, neg;
    if (free[0]) begin
      abits   = amount_bits_i[62:0];
      a2      = abits + 63'd1;
      nan_inf = (amount_bits_i[62:52] == 11'h7ff);
      neg     = amount_bits_i[63] && (abits != '0);
      side_q[0].err_in  <= nan_inf || neg || (dec_q > 5'(MaxDecimals));
      side_q[0].not_max <= (abits != 63'h7fef_ffff_ffff_ffff);
      side_q[0].e       <= 12'((abits[62:52] != '0) ? abits[62:52] : 11'd1) - 12'sd1075;
      m_q  <= (abits[62:52] != '0) ? {1'b1, abits[51:0]} : {1'b0, abits[51:0]};
      e_q  <= 12'((abits[62:52] != '0) ? abits[62:52] : 11'd1) - 12'sd1075;
      m2_q <= (a2[62:52] != '0) ? {1'b1, a2[51:0]} : {1'b0, a2[51:0]};
      e2_q <= 12'((a2[62:52] != '0) ? a2[62:52] : 11'd1) - 12'sd1075;
    end
    // sideband keeps pace with the multiplier stages
    for (int i = 1; i <= 4; i++) begin
      if (free[i]) side_q[i] <= side_q[i-1];
    end
  end

  // amount and its upper neighbour scaled side by side
  dtsd_pkg::dbl_t s_res, t_res;

  dtsd_scale u_scale_s (
    .clk_i (clk_i),
    .en_i  (free[4:1]),
    .m_i   (m_q),
    .e_i   (e_q),
    .x_i   (x),
    .res_o (s_res)
  );

  dtsd_scale u_scale_t (
    .clk_i (clk_i),
    .en_i  (free[4:1]),
    .m_i   (m2_q),
    .e_i   (e2_q),
    .x_i   (x),
    .res_o (t_res)
  );

  dtsd_finish u_finish (
    .clk_i   (clk_i),
    .en_i    (free[7:5]),
    .s_i     (s_res),
    .t_i     (t_res),
    .side_i  (side_q[4]),
    .x_i     (x),
    .xlen_i  (xlen),
    .mode_i  (mode_q),
    .value_o (scaled_value_o),
    .err_o   (error_code_o)
  );

  // an error result always carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != dtsd_pkg::ERR_NONE) |-> scaled_value_o == '0)
    else $error("error result with non-zero value");

  // an accepted transaction always lands in the decode stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transaction lost at decode");

  // a full stalled output stage must hold back the stage before it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-1] && !out_ready_i && vld_q[NumStages-2] |=> vld_q[NumStages-2])
    else $error("stage dropped while output stalled");

endmodule

/* rtl/core/dtsd_scale.sv */
// four-stage exact multiply by the scale and round to binary64
module dtsd_scale (
  input  logic               clk_i,
  input  logic [3:0]         en_i,
  input  logic [52:0]        m_i,
  input  logic signed [11:0] e_i,
  input  logic [63:0]        x_i,
  output dtsd_pkg::dbl_t     res_o
);

  logic [63:0] pp0_q, pp1_q;
  logic [52:0] pp2_q, pp3_q;
  logic signed [11:0] e1_q, e2_q, e3_q;
  logic [127:0] p2_q, p3_q, p2_d;
  logic [6:0]   len3_q, len_d;
  dtsd_pkg::dbl_t res_q, res_d;

  // stage 1: partial products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp0_q <= 64'(m_i[31:0]) * 64'(x_i[31:0]);
      pp1_q <= 64'(m_i[31:0]) * 64'(x_i[63:32]);
      pp2_q <= 53'(m_i[52:32]) * 53'(x_i[31:0]);
      pp3_q <= 53'(m_i[52:32]) * 53'(x_i[63:32]);
      e1_q  <= e_i;
    end
  end

  // stage 2: sum into the full product
  assign p2_d = 128'(pp0_q) + (128'(pp1_q) << 32) + (128'(pp2_q) << 32) + (128'(pp3_q) << 64);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p2_q <= p2_d;
      e2_q <= e1_q;
    end
  end

  // stage 3: leading one
  always_comb begin
    len_d = '0;
    for (int i = 0; i < 118; i++) begin
      if (p2_q[i]) len_d = 7'(i + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      p3_q   <= p2_q;
      len3_q <= len_d;
      e3_q   <= e2_q;
    end
  end

  // stage 4: shift to 53 bits, round to nearest even
  always_comb begin
    logic [6:0]   r, rr;
    logic [127:0] sh, gsh, mask;
    logic [53:0]  q;
    logic         guard, sticky;
    r      = len3_q - 7'd53;
    sh     = p3_q >> r;
    gsh    = p3_q >> (r - 7'd1);
    mask   = (128'd1 << (r - 7'd1)) - 128'd1;
    guard  = gsh[0];
    sticky = |(p3_q & mask);
    q      = sh[53:0];
    q      = q + 54'(guard && (sticky || q[0]));
    rr     = r + 7'(q[53]);
    if (len3_q <= 7'd53) begin
      res_d.sm = p3_q[52:0];
      res_d.se = 13'(e3_q);
      res_d.bl = len3_q[5:0];
      res_d.k  = '0;
    end else begin
      res_d.sm = q[53] ? q[53:1] : q[52:0];
      res_d.se = 13'(e3_q) + $signed({6'd0, rr});
      res_d.bl = 6'd53;
      res_d.k  = rr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* rtl/core/dtsd_finish.sv */
// three-stage integer split, rounding decision and result select
module dtsd_finish (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  dtsd_pkg::dbl_t      s_i,
  input  dtsd_pkg::dbl_t      t_i,
  input  dtsd_pkg::side_t     side_i,
  input  logic [63:0]         x_i,
  input  logic [6:0]          xlen_i,
  input  dtsd_pkg::rnd_mode_e mode_i,
  output logic [63:0]         value_o,
  output logic [1:0]          err_o
);

  // stage 1 results
  logic [63:0] ip1_q, fl1_q, xk1_q, xkm1_q;
  logic [52:0] f1_q;
  logic [5:0]  h1_q;
  logic h_ok1_q, geh1_q, win0_1_q, kz1_q, k_ok1_q, km1_ok1_q;
  logic s_big1_q, s_inf1_q, t_big1_q, err_in1_q, not_max1_q;

  always_ff @(posedge clk_i) begin
    logic signed [13:0] ssum, tsum;
    logic signed [12:0] neg, tneg, pm;
    logic [5:0]  n6;
    logic [63:0] tmp;
    logic [6:0]  km1;
    logic [63:0] ip;
    logic [52:0] f;
    logic [5:0]  h;
    logic        h_ok, geh;
    if (en_i[0]) begin
      ssum = $signed({8'd0, s_i.bl}) + 14'(s_i.se);
      tsum = $signed({8'd0, t_i.bl}) + 14'(t_i.se);
      neg  = -s_i.se;
      tneg = -t_i.se;
      n6   = neg[5:0];
      s_big1_q   <= (s_i.sm != '0) && (ssum > 14'sd64);
      s_inf1_q   <= (s_i.sm != '0) && (ssum > 14'sd1024);
      t_big1_q   <= (t_i.sm != '0) && (tsum > 14'sd64);
      err_in1_q  <= side_i.err_in;
      not_max1_q <= side_i.not_max;
      // integer and fraction parts
      ip   = '0;
      f    = '0;
      h    = '0;
      h_ok = 1'b0;
      geh  = 1'b0;
      tmp  = 64'(s_i.sm) >> (n6 - 6'd1);
      if (s_i.sm == '0) begin
        ip = '0;
      end else if (s_i.se >= 0) begin
        ip = 64'(s_i.sm) << s_i.se[5:0];
      end else if (neg > 13'sd63) begin
        f    = s_i.sm;
        h    = 6'd63;
        h_ok = (neg == 13'sd64);
      end else begin
        ip   = 64'(s_i.sm) >> n6;
        f    = s_i.sm & ((53'd1 << n6) - 53'd1);
        h    = n6 - 6'd1;
        h_ok = 1'b1;
        geh  = tmp[0];
      end
      ip1_q   <= ip;
      f1_q    <= f;
      h1_q    <= h;
      h_ok1_q <= h_ok;
      geh1_q  <= geh;
      // next double, floored
      if (t_i.se >= 0) fl1_q <= 64'(t_i.sm) << t_i.se[5:0];
      else if (tneg > 13'sd63) fl1_q <= '0;
      else fl1_q <= 64'(t_i.sm) >> tneg[5:0];
      // tolerance terms
      pm = -13'(side_i.e) - 13'sd1;
      win0_1_q <= (pm <= 0) || ((pm < 13'sd64) && ($signed({6'd0, xlen_i}) > pm));
      km1       = s_i.k - 7'd1;
      kz1_q     <= (s_i.k == '0);
      k_ok1_q   <= (s_i.k < 7'd64);
      km1_ok1_q <= (km1 < 7'd64);
      xk1_q     <= x_i >> s_i.k[5:0];
      xkm1_q    <= x_i >> km1[5:0];
    end
  end

  // stage 2: tie window, exactness and down correction
  logic [63:0] ip2_q;
  logic        up2_q;
  logic [1:0]  err2_q;

  always_ff @(posedge clk_i) begin
    logic [63:0] half, dev, f64, g, gh;
    logic        in_tie, ok3, upd, up;
    dtsd_pkg::err_e err;
    if (en_i[1]) begin
      f64  = 64'(f1_q);
      half = 64'd1 << h1_q;
      dev  = (f64 >= half) ? f64 - half : half - f64;
      gh   = (64'd1 << (7'(h1_q) + 7'd1)) - f64;
      g    = (f64 == '0) ? '0 : (geh1_q ? gh : f64);
      if (f64 == '0) in_tie = win0_1_q;
      else if (!h_ok1_q) in_tie = 1'b0;
      else in_tie = (dev == '0) || (k_ok1_q && dev <= xk1_q);
      if (g == '0) ok3 = 1'b1;
      else if (kz1_q) ok3 = ((g + 64'd1) >> 1) <= x_i;
      else ok3 = km1_ok1_q && (g <= xkm1_q);
      upd = (f64 != '0) && not_max1_q &&
            (t_big1_q || ((ip1_q != '1) && (65'(fl1_q) >= 65'(ip1_q) + 65'd1)));
      case (mode_i)
        dtsd_pkg::RM_NEAREST:   up = geh1_q;
        dtsd_pkg::RM_HALF_EVEN: up = in_tie ? ip1_q[0] : geh1_q;
        dtsd_pkg::RM_DOWN:      up = upd;
        dtsd_pkg::RM_EXACT:     up = geh1_q;
        default:                up = geh1_q;
      endcase
      if (err_in1_q) err = dtsd_pkg::ERR_INPUT;
      else if (s_inf1_q && mode_i == dtsd_pkg::RM_EXACT) err = dtsd_pkg::ERR_PREC;
      else if (s_big1_q) err = dtsd_pkg::ERR_RANGE;
      else if (mode_i == dtsd_pkg::RM_EXACT && !ok3) err = dtsd_pkg::ERR_PREC;
      else err = dtsd_pkg::ERR_NONE;
      ip2_q  <= ip1_q;
      up2_q  <= up;
      err2_q <= err;
    end
  end

  // stage 3: increment and final select
  logic [63:0] val3_q;
  logic [1:0]  err3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      if (err2_q != dtsd_pkg::ERR_NONE) begin
        val3_q <= '0;
        err3_q <= err2_q;
      end else if (up2_q && ip2_q == '1) begin
        val3_q <= '0;
        err3_q <= dtsd_pkg::ERR_RANGE;
      end else begin
        val3_q <= ip2_q + 64'(up2_q);
        err3_q <= dtsd_pkg::ERR_NONE;
      end
    end
  end

  assign value_o = val3_q;
  assign err_o   = err3_q;

endmodule

/* test/testbench.sv */
// self-checking testbench of the binary64 to scaled decimal integer converter
module testbench;
  import dtsd_pkg::*;

  typedef struct {
    logic [63:0] value;
    err_e        code;
  } conversion_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = CFG_DECIMALS;
  logic [4:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] amount_bits_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] scaled_value_o;
  logic [1:0]  error_code_o;

  // local copy of the two registers, as the block should hold them
  logic [4:0]  cur_decimals = 5'd0;
  rnd_mode_e   cur_mode = RM_NEAREST;

  conversion_t pending_q[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_off = 0;    // cycles left of a forced receiver hold-off

  localparam int DrainCycles = 20;

  double_to_scaled_decimal_integer dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int bit_length(input logic [127:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  // mantissa and exponent of a non-negative pattern
  function automatic void unpack_double(input logic [63:0] bits, output logic [52:0] m,
                                        output int e);
    int ex;
    ex = int'(bits[62:52]);
    m  = {(ex != 0), bits[51:0]};
    e  = (ex != 0 ? ex : 1) - 1075;
  endfunction

  // m * 2^e * x rounded to 53 bits, nearest even
  function automatic void scale_round(input logic [52:0] m, input int e, input logic [63:0] x,
                                      output logic [52:0] sm, output int se, output bit inf);
    logic [127:0] p;
    logic [127:0] q;
    int len;
    int r;
    bit guard;
    bit sticky;
    p   = 128'(m) * 128'(x);
    len = bit_length(p);
    if (len <= 53) begin
      sm = p[52:0];
      se = e;
    end else begin
      r      = len - 53;
      q      = p >> r;
      guard  = p[r-1];
      sticky = (p & ((128'd1 << (r - 1)) - 128'd1)) != 0;
      if (guard && (sticky || q[0])) q = q + 1;
      if (q[53]) begin
        q = q >> 1;
        r++;
      end
      sm = q[52:0];
      se = e + r;
    end
    inf = sm != 0 && bit_length(128'(sm)) + se > 1024;
  endfunction

  function automatic bit exceeds_64(input logic [52:0] sm, input int se, input bit inf);
    return inf || (sm != 0 && bit_length(128'(sm)) + se > 64);
  endfunction

  function automatic conversion_t convert_amount(input logic [63:0] bits, input logic [4:0] dec,
                                                 input rnd_mode_e mode);
    conversion_t res;
    logic [63:0] abits, x, ip, f, half, dev, g, fl;
    logic [64:0] wide;
    logic [52:0] m, sm, m2, tsm;
    int e, se, h, k, n, p, e2, tse;
    bit inf, tinf, gehalf, up, in_tie, ok;
    res.value = '0;
    res.code  = ERR_NONE;
    abits = {1'b0, bits[62:0]};
    if (&bits[62:52] || (bits[63] && abits != 0) || dec > MaxDecimals) begin
      res.code = ERR_INPUT;
      return res;
    end
    x = 64'd1;
    for (int i = 0; i < dec; i++) x = x * 10;
    unpack_double(abits, m, e);
    scale_round(m, e, x, sm, se, inf);
    if (inf && mode == RM_EXACT) begin
      res.code = ERR_PREC;
      return res;
    end
    if (exceeds_64(sm, se, inf)) begin
      res.code = ERR_RANGE;
      return res;
    end
    h = 0;
    f = 0;
    if (sm == 0) ip = 0;
    else if (se >= 0) ip = 64'(sm) << se;
    else begin
      n = -se;
      h = n - 1;
      if (n >= 64) begin
        ip = 0;
        f  = 64'(sm);
      end else begin
        ip = 64'(sm) >> n;
        f  = 64'(sm) & ((64'd1 << n) - 1);
      end
    end
    gehalf = f != 0 && h < 64 && (f >> h) != 0;
    k  = se - e;
    up = gehalf;
    case (mode)
      RM_HALF_EVEN: begin
        if (f == 0) begin
          p = -e - 1;
          in_tie = p <= 0 || (p < 64 && (x >> p) != 0);
        end else if (h >= 64) begin
          in_tie = 0;
        end else begin
          half   = 64'd1 << h;
          dev    = f >= half ? f - half : half - f;
          in_tie = dev == 0 || (k < 64 && dev <= (x >> k));
        end
        if (in_tie) up = ip[0];
      end
      RM_DOWN: begin
        up = 0;
        // the next double up decides whether floor is lifted by one
        if (f != 0 && abits != 64'h7FEF_FFFF_FFFF_FFFF) begin
          unpack_double(abits + 1, m2, e2);
          scale_round(m2, e2, x, tsm, tse, tinf);
          if (exceeds_64(tsm, tse, tinf)) up = 1;
          else begin
            if (tse >= 0) fl = 64'(tsm) << tse;
            else fl = (-tse >= 64) ? 64'd0 : (64'(tsm) >> -tse);
            up = ip != '1 && fl >= ip + 1;
          end
        end
      end
      RM_EXACT: begin
        g = 0;
        if (f != 0) begin
          wide = (65'd1 << (h + 1)) - 65'(f);
          g = gehalf ? wide[63:0] : f;
        end
        if (g == 0) ok = 1;
        else if (k == 0) ok = ((65'(g) + 1) >> 1) <= 65'(x);
        else ok = (k - 1) < 64 && g <= (x >> (k - 1));
        if (!ok) begin
          res.code = ERR_PREC;
          return res;
        end
      end
      default: ;
    endcase
    if (up) begin
      if (ip == '1) begin
        res.code = ERR_RANGE;
        return res;
      end
      res.value = ip + 1;
    end else begin
      res.value = ip;
    end
    return res;
  endfunction

  // ------------------------------------------------------------------ drivers

  // one input transaction; expectation is logged at the accepting edge
  task automatic send_amount(input logic [63:0] bits);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    amount_bits_i <= bits;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(convert_amount(bits, cur_decimals, cur_mode));
  endtask

  // wait until the pipe is empty before touching the registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [4:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == CFG_DECIMALS) cur_decimals = data;
    else cur_mode = rnd_mode_e'(data[1:0]);
  endtask

  task automatic configure(input logic [4:0] dec, input rnd_mode_e mode);
    wait_idle();
    write_reg(CFG_DECIMALS, dec);
    // upper data bits are don't-care for the mode register
    write_reg(CFG_MODE, {3'($urandom_range(0, 7)), mode});
    cfg_we_i <= 1'b0;
  endtask

  // receiver: random stalls, or a forced hold-off counted down here
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off    <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    conversion_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h code %0d",
                                       scaled_value_o, error_code_o);
      end else begin
        want = pending_q.pop_front();
        if (scaled_value_o !== want.value || error_code_o !== want.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h code %0d, got %h code %0d",
                     want.value, want.code, scaled_value_o, error_code_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // mostly plausible money amounts, some odd patterns and raw noise
  function automatic logic [63:0] random_amount();
    int sel;
    logic [63:0] b;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $realtobits($urandom_range(0, 10_000_000) / 100.0);
    if (sel < 6) return $realtobits($urandom_range(0, 1_000_000) / 1000.0);
    if (sel < 8) begin
      // non-negative with exponent around unity
      b = {$urandom, $urandom};
      b[63] = 1'b0;
      b[62:52] = 11'($urandom_range(1023 - 60, 1023 + 66));
      return b;
    end
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [63:0] specials[$];
    specials = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                 64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0000,
                 $realtobits(-1.0), 64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                 64'h000F_FFFF_FFFF_FFFF, $realtobits(0.5), $realtobits(1.5),
                 $realtobits(2.5), $realtobits(0.1), $realtobits(1.005),
                 $realtobits(0.29), $realtobits(1.8446744073709552e19),
                 $realtobits(1.8446744073709550e19), $realtobits(1.0e19),
                 $realtobits(3.0), $realtobits(123.456)};
    // each mode at the decimal extremes, plus out-of-range decimals
    foreach (specials[i]) begin
      if (i % 5 == 0)
        configure((i / 5) % 2 ? 5'd18 : 5'd0, rnd_mode_e'(i / 5));
      send_amount(specials[i]);
    end
    for (int md = 0; md < 4; md++) begin
      configure(md % 2 ? 5'd31 : 5'd19, rnd_mode_e'(md));
      send_amount(specials[md + 9]);
      configure(5'd2, rnd_mode_e'(md));
      send_amount(specials[md + 9]);
      send_amount(specials[12 + md]);
    end
  endtask

  task automatic test_random(input int items);
    for (int i = 0; i < items; i++) begin
      if (i % 25 == 0)
        configure($urandom_range(0, 9) == 0 ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 18)),
                  rnd_mode_e'($urandom_range(0, 3)));
      send_amount(random_amount());
    end
  endtask

  // receiver holds off long enough for the pipe to fill and stall input
  task automatic test_backpressure();
    configure(5'd6, RM_HALF_EVEN);
    @(posedge clk_i);
    hold_off <= 60;
    for (int i = 0; i < 30; i++) send_amount(random_amount());
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_amount(random_amount());
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 10; i++) send_amount(random_amount());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    // idling phases: none, sender idle, receiver stalling, both
    send_idle_pct = 0;  stall_pct = 0;  test_random(80);
    send_idle_pct = 58; stall_pct = 0;  test_random(80);
    send_idle_pct = 0;  stall_pct = 58; test_random(80);
    send_idle_pct = 27; stall_pct = 27; test_random(80);
    send_idle_pct = 0;  stall_pct = 0;  test_backpressure();
    test_drain_pause();
    wait_idle();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
